### sv/ems_pkg.sv
// Shared types and constants for the engine mode sequencer.
// Depends on nothing; used by the core and its checker.
package ems_pkg;

    localparam int DELAY_BITS = 16;
    localparam int LANE_W     = (DELAY_BITS < 16) ? DELAY_BITS : 16;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int TICKS_W    = 32;

    localparam logic [2:0] M_SAFE = 3'd0;
    localparam logic [2:0] M_ARM  = 3'd1;
    localparam logic [2:0] M_MONO = 3'd2;
    localparam logic [2:0] M_BI   = 3'd3;
    localparam logic [2:0] M_DUMP = 3'd4;
    localparam logic [2:0] M_FILL = 3'd5;

    localparam logic [2:0] DK_NONE      = 3'd0;
    localparam logic [2:0] DK_BI_MONO   = 3'd1;
    localparam logic [2:0] DK_MONO_ARM  = 3'd2;
    localparam logic [2:0] DK_ARM_MONO  = 3'd3;
    localparam logic [2:0] DK_MONO_BI   = 3'd4;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_CMD   = 2'd1;
    localparam logic [1:0] OP_FORCE = 2'd2;

    localparam logic [3:0] REQ_ARM_ALIAS = 4'hF;

    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_ARM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BI_DUMP_FILL = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [3:0] requested_state;
    } t_in;

    typedef struct packed {
        logic [2:0]         current_state;
        logic [2:0]         opmode_shown;
        logic               move_pending;
        logic [2:0]         decay_kind;
        logic [TICKS_W-1:0] transit_ticks;
        logic               dump_active;
        logic               refuel;
        logic               invalid_request;
    } t_out;

endpackage

### sv/engine_mode_sequencer_core.sv
// Engine mode sequencer: six-mode state machine with timed, configurable moves.
// Depends on ems_pkg for payload types, mode codes and register indexes.
// Latency: a result is valid the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; the output register holds a stalled result
// and input ready drops only while that result waits.
// Reset (synchronous, active low): safe mode, no move, no decay, delays zero.
module engine_mode_sequencer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ems_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ems_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ems_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ems_pkg::t_out                  o_out
);

    typedef logic [ems_pkg::LANE_W-1:0] t_delay;

    typedef struct packed {
        logic [2:0]                  mode_now;
        logic [2:0]                  hop_mode;
        logic [2:0]                  goal_mode;
        logic [2:0]                  decay_code;
        logic [2:0]                  shown_mode;
        t_delay                      countdown;
        logic [ems_pkg::TICKS_W-1:0] decay_elapsed;
    } t_st;

    logic [ems_pkg::CFG_W-1:0] r_dly_sa, r_dly_mono, r_dly_bdf;
    t_st                       r_st, n_st;
    logic                      r_out_valid;
    ems_pkg::t_out             r_out, n_out;
    logic                      w_accept;

    function automatic t_delay f_lane(logic [ems_pkg::CFG_W-1:0] reg_v, int k);
        return reg_v[16*k +: ems_pkg::LANE_W];
    endfunction

    function automatic t_st f_land(t_st s, logic [2:0] m);
        t_st r;
        r = s;
        if (m != r.mode_now) begin
            r.mode_now      = m;
            r.shown_mode    = m;
            r.decay_code    = ems_pkg::DK_NONE;
            r.decay_elapsed = '0;
        end
        return r;
    endfunction

    function automatic t_st f_set_decay(t_st s, logic [2:0] f);
        t_st r;
        r = s;
        r.decay_elapsed = '0;
        r.shown_mode    = r.hop_mode;
        if (r.mode_now == ems_pkg::M_BI && f == ems_pkg::M_MONO)
            r.decay_code = ems_pkg::DK_BI_MONO;
        else if (r.mode_now == ems_pkg::M_MONO && f == ems_pkg::M_ARM)
            r.decay_code = ems_pkg::DK_MONO_ARM;
        else if (r.mode_now == ems_pkg::M_ARM && f == ems_pkg::M_MONO)
            r.decay_code = ems_pkg::DK_ARM_MONO;
        else if (r.mode_now == ems_pkg::M_MONO && f == ems_pkg::M_BI)
            r.decay_code = ems_pkg::DK_MONO_BI;
        else
            r.decay_code = ems_pkg::DK_NONE;
        return r;
    endfunction

    function automatic t_st f_begin_last(t_st s, logic [2:0] goal, t_delay dly);
        t_st r;
        r = s;
        r.goal_mode = goal;
        r.hop_mode  = goal;
        r.countdown = dly;
        if (dly == '0) r = f_land(r, goal);
        return r;
    endfunction

    function automatic t_st f_arrive(t_st s, logic [2:0] m, t_delay d_ma, t_delay d_mb);
        t_st r;
        r = f_land(s, m);
        if (r.hop_mode != r.goal_mode) begin
            if (r.goal_mode == ems_pkg::M_BI) begin
                r = f_begin_last(r, ems_pkg::M_BI, d_mb);
                r = f_set_decay(r, ems_pkg::M_BI);
            end else if (r.goal_mode == ems_pkg::M_ARM) begin
                r = f_begin_last(r, ems_pkg::M_ARM, d_ma);
                r = f_set_decay(r, ems_pkg::M_ARM);
            end else begin
                r.hop_mode = r.goal_mode;
            end
        end
        return r;
    endfunction

    function automatic t_st f_begin(t_st s, logic [2:0] goal, t_delay dly, logic [2:0] hop,
                                    t_delay d_ma, t_delay d_mb);
        t_st r;
        r = s;
        r.goal_mode = goal;
        r.hop_mode  = hop;
        r.countdown = dly;
        if (dly == '0) r = f_arrive(r, hop, d_ma, d_mb);
        return r;
    endfunction

    always_comb begin
        t_st        s;
        logic       good;
        logic       bad;
        logic [2:0] req;
        logic [3:0] raw;
        t_delay     d_sa, d_sd, d_sf, d_as, d_am, d_ms, d_ma, d_mb, d_bs, d_bm, d_ds, d_fs;
        s    = r_st;
        bad  = 1'b0;
        raw  = $unsigned(i_in.requested_state);
        good = 1'b1;
        req  = ems_pkg::M_SAFE;
        d_sa = f_lane(r_dly_sa, 0);
        d_sd = f_lane(r_dly_sa, 1);
        d_sf = f_lane(r_dly_sa, 2);
        d_as = f_lane(r_dly_sa, 3);
        d_am = f_lane(r_dly_mono, 0);
        d_ms = f_lane(r_dly_mono, 1);
        d_ma = f_lane(r_dly_mono, 2);
        d_mb = f_lane(r_dly_mono, 3);
        d_bs = f_lane(r_dly_bdf, 0);
        d_bm = f_lane(r_dly_bdf, 1);
        d_ds = f_lane(r_dly_bdf, 2);
        d_fs = f_lane(r_dly_bdf, 3);
        if (raw == ems_pkg::REQ_ARM_ALIAS) req = ems_pkg::M_ARM;
        else if (raw <= 4'd5) req = raw[2:0];
        else good = 1'b0;

        case (i_in.mode)
            ems_pkg::OP_TICK: begin
                if (s.countdown != '0) s.countdown = s.countdown - 1'b1;
                if (s.decay_code != ems_pkg::DK_NONE && s.decay_elapsed != '1)
                    s.decay_elapsed = s.decay_elapsed + 1'b1;
            end
            ems_pkg::OP_CMD: begin
                if (s.hop_mode != s.mode_now) begin
                    if (s.countdown == '0) s = f_arrive(s, s.hop_mode, d_ma, d_mb);
                end else if (!good) begin
                    bad = 1'b1;
                end else begin
                    case (s.mode_now)
                        ems_pkg::M_SAFE: begin
                            if (req == ems_pkg::M_ARM) s = f_begin(s, req, d_sa, req, d_ma, d_mb);
                            else if (req == ems_pkg::M_DUMP)
                                s = f_begin(s, req, d_sd, req, d_ma, d_mb);
                            else if (req == ems_pkg::M_FILL)
                                s = f_begin(s, req, d_sf, req, d_ma, d_mb);
                            else bad = 1'b1;
                        end
                        ems_pkg::M_ARM: begin
                            if (req == ems_pkg::M_SAFE) begin
                                s = f_begin(s, req, d_as, req, d_ma, d_mb);
                            end else if (req == ems_pkg::M_MONO) begin
                                s = f_begin(s, req, d_am, req, d_ma, d_mb);
                                s = f_set_decay(s, ems_pkg::M_MONO);
                            end else if (req == ems_pkg::M_BI) begin
                                s = f_begin(s, req, d_am, ems_pkg::M_MONO, d_ma, d_mb);
                                s = f_set_decay(s, ems_pkg::M_MONO);
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        ems_pkg::M_MONO: begin
                            if (req == ems_pkg::M_SAFE) begin
                                s = f_begin(s, req, d_ms, req, d_ma, d_mb);
                            end else if (req == ems_pkg::M_ARM) begin
                                s = f_begin(s, req, d_ma, req, d_ma, d_mb);
                                s = f_set_decay(s, ems_pkg::M_ARM);
                            end else if (req == ems_pkg::M_BI) begin
                                s = f_begin(s, req, d_mb, req, d_ma, d_mb);
                                s = f_set_decay(s, ems_pkg::M_BI);
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        ems_pkg::M_BI: begin
                            if (req == ems_pkg::M_SAFE) begin
                                s = f_begin(s, req, d_bs, req, d_ma, d_mb);
                            end else if (req == ems_pkg::M_ARM) begin
                                s = f_begin(s, req, d_bm, ems_pkg::M_MONO, d_ma, d_mb);
                                s = f_set_decay(s, ems_pkg::M_MONO);
                            end else if (req == ems_pkg::M_MONO) begin
                                s = f_begin(s, req, d_bm, req, d_ma, d_mb);
                                s = f_set_decay(s, ems_pkg::M_MONO);
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        ems_pkg::M_DUMP: begin
                            if (req == ems_pkg::M_SAFE) s = f_begin(s, req, d_ds, req, d_ma, d_mb);
                            else bad = 1'b1;
                        end
                        ems_pkg::M_FILL: begin
                            if (req == ems_pkg::M_SAFE) s = f_begin(s, req, d_fs, req, d_ma, d_mb);
                            else bad = 1'b1;
                        end
                        default: bad = 1'b1;
                    endcase
                end
            end
            ems_pkg::OP_FORCE: begin
                if (good) s = f_begin(s, req, '0, req, d_ma, d_mb);
                else bad = 1'b1;
            end
            default: ;
        endcase

        n_st                  = s;
        n_out.current_state   = s.mode_now;
        n_out.opmode_shown    = s.shown_mode;
        n_out.move_pending    = (s.hop_mode != s.mode_now);
        n_out.decay_kind      = s.decay_code;
        n_out.transit_ticks   = s.decay_elapsed;
        n_out.dump_active     = (s.mode_now == ems_pkg::M_DUMP);
        n_out.refuel          = (s.mode_now == ems_pkg::M_FILL);
        n_out.invalid_request = bad;
    end

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_sa           <= '0;
            r_dly_mono         <= '0;
            r_dly_bdf          <= '0;
            r_st.mode_now      <= ems_pkg::M_SAFE;
            r_st.hop_mode      <= ems_pkg::M_SAFE;
            r_st.goal_mode     <= ems_pkg::M_SAFE;
            r_st.decay_code    <= ems_pkg::DK_NONE;
            r_st.shown_mode    <= ems_pkg::M_SAFE;
            r_st.countdown     <= '0;
            r_st.decay_elapsed <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    ems_pkg::CFG_SAFE_ARM:     r_dly_sa   <= i_cfg_wdata;
                    ems_pkg::CFG_MONO:         r_dly_mono <= i_cfg_wdata;
                    ems_pkg::CFG_BI_DUMP_FILL: r_dly_bdf  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_out <= n_out;
    end

endmodule

### sv/ems_checker.sv
// Port-level checker for engine_mode_sequencer_core, attached by bind.
// Depends on ems_pkg for the payload types.
module ems_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ems_pkg::t_out o_out
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output transaction changed while stalled");

    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted transaction produced no result");

    a_ready_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a waiting result");

    a_decay_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.decay_kind == ems_pkg::DK_NONE |-> o_out.transit_ticks == '0)
        else $error("transit ticks nonzero with no decay");

endmodule

bind engine_mode_sequencer_core ems_checker u_ems_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

### sim/tb.sv
// Self-checking testbench for engine_mode_sequencer_core: directed and random
// mode commands, ticks and forced moves, with random idling on both channels.
// Depends on ems_pkg and the core; the scoreboard predicts each status transaction.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [3:0] REQ_FIRST_BAD = 4'd6;
    localparam logic [3:0] REQ_HIGH_BAD  = 4'd7;
    localparam logic [3:0] REQ_NEG_BAD   = 4'hA;
    localparam logic [3:0] REQ_MOST_NEG  = 4'h8;
    localparam int         MAX_WAIT      = 18;
    localparam int         CYCLE_LIMIT   = 400_000;
    localparam int         PHASES        = 8;
    localparam int         PHASE_ITEMS   = 92;

    class engine_mode_scoreboard;
        logic [ems_pkg::CFG_W-1:0]   delay_regs [3] = '{default: '0};
        logic [2:0]                  mode_now    = ems_pkg::M_SAFE;
        logic [2:0]                  hop_mode    = ems_pkg::M_SAFE;
        logic [2:0]                  goal_mode   = ems_pkg::M_SAFE;
        logic [2:0]                  decay_code  = ems_pkg::DK_NONE;
        logic [2:0]                  shown_mode  = ems_pkg::M_SAFE;
        logic [15:0]                 countdown   = '0;
        logic [ems_pkg::TICKS_W-1:0] decay_ticks = '0;
        ems_pkg::t_out               expected_status_q [$];
        int                          errors = 0;

        function void write_delays(logic [ems_pkg::CFG_IDX_W-1:0] idx,
                                   logic [ems_pkg::CFG_W-1:0] value);
            if (idx <= ems_pkg::CFG_BI_DUMP_FILL) begin
                delay_regs[idx] = value;
            end
        endfunction

        function logic [15:0] lane_delay(logic [ems_pkg::CFG_IDX_W-1:0] idx, int k);
            logic [ems_pkg::CFG_W-1:0] r;
            r = delay_regs[idx];
            return 16'(r[16*k +: ems_pkg::LANE_W]);
        endfunction

        function void land_in(logic [2:0] s);
            if (s != mode_now) begin
                mode_now    = s;
                shown_mode  = s;
                decay_code  = ems_pkg::DK_NONE;
                decay_ticks = '0;
            end
        endfunction

        function void mark_decay(logic [2:0] f);
            decay_ticks = '0;
            shown_mode  = hop_mode;
            if (mode_now == ems_pkg::M_BI && f == ems_pkg::M_MONO)
                decay_code = ems_pkg::DK_BI_MONO;
            else if (mode_now == ems_pkg::M_MONO && f == ems_pkg::M_ARM)
                decay_code = ems_pkg::DK_MONO_ARM;
            else if (mode_now == ems_pkg::M_ARM && f == ems_pkg::M_MONO)
                decay_code = ems_pkg::DK_ARM_MONO;
            else if (mode_now == ems_pkg::M_MONO && f == ems_pkg::M_BI)
                decay_code = ems_pkg::DK_MONO_BI;
            else
                decay_code = ems_pkg::DK_NONE;
        endfunction

        function void start_final_hop(logic [2:0] goal, logic [15:0] delay);
            goal_mode = goal;
            hop_mode  = goal;
            countdown = delay;
            if (delay == 0) land_in(goal);
        endfunction

        function void reach_hop(logic [2:0] s);
            land_in(s);
            if (hop_mode != goal_mode) begin
                // continue from monoprop toward the goal
                if (goal_mode == ems_pkg::M_BI) begin
                    start_final_hop(ems_pkg::M_BI, lane_delay(ems_pkg::CFG_MONO, 3));
                    mark_decay(ems_pkg::M_BI);
                end else if (goal_mode == ems_pkg::M_ARM) begin
                    start_final_hop(ems_pkg::M_ARM, lane_delay(ems_pkg::CFG_MONO, 2));
                    mark_decay(ems_pkg::M_ARM);
                end else begin
                    hop_mode = goal_mode;
                end
            end
        endfunction

        function void start_move(logic [2:0] goal, logic [15:0] delay, logic [2:0] hop);
            goal_mode = goal;
            hop_mode  = hop;
            countdown = delay;
            if (delay == 0) reach_hop(hop);
        endfunction

        function bit route_command(logic [2:0] r);
            bit rejected;
            rejected = 1'b0;
            case (mode_now)
                ems_pkg::M_SAFE: begin
                    if (r == ems_pkg::M_ARM)
                        start_move(r, lane_delay(ems_pkg::CFG_SAFE_ARM, 0), r);
                    else if (r == ems_pkg::M_DUMP)
                        start_move(r, lane_delay(ems_pkg::CFG_SAFE_ARM, 1), r);
                    else if (r == ems_pkg::M_FILL)
                        start_move(r, lane_delay(ems_pkg::CFG_SAFE_ARM, 2), r);
                    else rejected = 1'b1;
                end
                ems_pkg::M_ARM: begin
                    if (r == ems_pkg::M_SAFE) begin
                        start_move(r, lane_delay(ems_pkg::CFG_SAFE_ARM, 3), r);
                    end else if (r == ems_pkg::M_MONO) begin
                        start_move(r, lane_delay(ems_pkg::CFG_MONO, 0), r);
                        mark_decay(ems_pkg::M_MONO);
                    end else if (r == ems_pkg::M_BI) begin
                        start_move(r, lane_delay(ems_pkg::CFG_MONO, 0), ems_pkg::M_MONO);
                        mark_decay(ems_pkg::M_MONO);
                    end else begin
                        rejected = 1'b1;
                    end
                end
                ems_pkg::M_MONO: begin
                    if (r == ems_pkg::M_SAFE) begin
                        start_move(r, lane_delay(ems_pkg::CFG_MONO, 1), r);
                    end else if (r == ems_pkg::M_ARM) begin
                        start_move(r, lane_delay(ems_pkg::CFG_MONO, 2), r);
                        mark_decay(ems_pkg::M_ARM);
                    end else if (r == ems_pkg::M_BI) begin
                        start_move(r, lane_delay(ems_pkg::CFG_MONO, 3), r);
                        mark_decay(ems_pkg::M_BI);
                    end else begin
                        rejected = 1'b1;
                    end
                end
                ems_pkg::M_BI: begin
                    if (r == ems_pkg::M_SAFE) begin
                        start_move(r, lane_delay(ems_pkg::CFG_BI_DUMP_FILL, 0), r);
                    end else if (r == ems_pkg::M_ARM) begin
                        start_move(r, lane_delay(ems_pkg::CFG_BI_DUMP_FILL, 1),
                                   ems_pkg::M_MONO);
                        mark_decay(ems_pkg::M_MONO);
                    end else if (r == ems_pkg::M_MONO) begin
                        start_move(r, lane_delay(ems_pkg::CFG_BI_DUMP_FILL, 1), r);
                        mark_decay(ems_pkg::M_MONO);
                    end else begin
                        rejected = 1'b1;
                    end
                end
                ems_pkg::M_DUMP: begin
                    if (r == ems_pkg::M_SAFE)
                        start_move(r, lane_delay(ems_pkg::CFG_BI_DUMP_FILL, 2), r);
                    else rejected = 1'b1;
                end
                ems_pkg::M_FILL: begin
                    if (r == ems_pkg::M_SAFE)
                        start_move(r, lane_delay(ems_pkg::CFG_BI_DUMP_FILL, 3), r);
                    else rejected = 1'b1;
                end
                default: rejected = 1'b1;
            endcase
            return rejected;
        endfunction

        function void note_command(ems_pkg::t_in item);
            logic [3:0]    raw;
            logic [2:0]    req;
            bit            good;
            bit            bad;
            ems_pkg::t_out status;
            raw  = item.requested_state;
            req  = ems_pkg::M_SAFE;
            good = 1'b1;
            bad  = 1'b0;
            if (raw == ems_pkg::REQ_ARM_ALIAS) req = ems_pkg::M_ARM;
            else if (raw <= 4'd5) req = raw[2:0];
            else good = 1'b0;

            case (item.mode)
                ems_pkg::OP_TICK: begin
                    if (countdown != 0) countdown = countdown - 1'b1;
                    if (decay_code != ems_pkg::DK_NONE && decay_ticks != '1) begin
                        decay_ticks = decay_ticks + 1'b1;
                    end
                end
                ems_pkg::OP_CMD: begin
                    if (hop_mode != mode_now) begin
                        if (countdown == 0) reach_hop(hop_mode);
                    end else if (!good) begin
                        bad = 1'b1;
                    end else begin
                        bad = route_command(req);
                    end
                end
                ems_pkg::OP_FORCE: begin
                    if (good) start_move(req, 16'd0, req);
                    else bad = 1'b1;
                end
                default: ;
            endcase

            status.current_state   = mode_now;
            status.opmode_shown    = shown_mode;
            status.move_pending    = (hop_mode != mode_now);
            status.decay_kind      = decay_code;
            status.transit_ticks   = decay_ticks;
            status.dump_active     = (mode_now == ems_pkg::M_DUMP);
            status.refuel          = (mode_now == ems_pkg::M_FILL);
            status.invalid_request = bad;
            expected_status_q.push_back(status);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_status(ems_pkg::t_out got);
            ems_pkg::t_out want;
            if (expected_status_q.size() == 0) begin
                errors++;
                $error("status transaction arrived with nothing expected");
                return;
            end
            want = expected_status_q.pop_front();
            compare_field("current_state", want.current_state, got.current_state);
            compare_field("opmode_shown", want.opmode_shown, got.opmode_shown);
            compare_field("move_pending", want.move_pending, got.move_pending);
            compare_field("decay_kind", want.decay_kind, got.decay_kind);
            compare_field("transit_ticks", want.transit_ticks, got.transit_ticks);
            compare_field("dump_active", want.dump_active, got.dump_active);
            compare_field("refuel", want.refuel, got.refuel);
            compare_field("invalid_request", want.invalid_request, got.invalid_request);
        endfunction

        function int outstanding();
            return expected_status_q.size();
        endfunction
    endclass

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          cfg_wr_en  = 1'b0;
    logic [ems_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [ems_pkg::CFG_W-1:0]     cfg_wdata  = '0;
    logic                          in_valid   = 1'b0;
    logic                          in_ready;
    ems_pkg::t_in                  in_item    = '0;
    logic                          out_valid;
    logic                          out_ready  = 1'b0;
    ems_pkg::t_out                 out_status;

    bit                            in_burst   = 1'b0;
    bit                            out_burst  = 1'b0;
    int                            cycle_count = 0;

    engine_mode_scoreboard sb = new();

    engine_mode_sequencer_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_status)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int draw_wait(bit burst);
        if (burst || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [3:0] mode_code(logic [2:0] m);
        return {1'b0, m};
    endfunction

    function automatic ems_pkg::t_in mk_item(logic [1:0] op, logic [3:0] code);
        ems_pkg::t_in item;
        item.mode            = op;
        item.requested_state = code;
        return item;
    endfunction

    function automatic ems_pkg::t_in random_item();
        int  pick;
        int  code;
        logic [1:0] op;
        logic [3:0] req;
        pick = $urandom_range(0, 99);
        if (pick < 45) op = ems_pkg::OP_TICK;
        else if (pick < 80) op = ems_pkg::OP_CMD;
        else if (pick < 93) op = ems_pkg::OP_FORCE;
        else op = OP_UNUSED;
        if ($urandom_range(0, 6) == 0) begin
            req = 4'($urandom);
        end else begin
            code = $urandom_range(0, 6);
            req  = (code == 6) ? ems_pkg::REQ_ARM_ALIAS : 4'(code);
        end
        return mk_item(op, req);
    endfunction

    function automatic logic [ems_pkg::CFG_W-1:0] short_delays();
        logic [ems_pkg::CFG_W-1:0] v;
        for (int k = 0; k < 4; k++) begin
            v[16*k +: 16] = 16'($urandom_range(0, 5));
        end
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(ems_pkg::t_in item);
        int gap;
        gap = draw_wait(in_burst);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_command(item);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0) @(negedge clk);
    endtask

    task automatic write_delay_regs(logic [ems_pkg::CFG_W-1:0] d0,
                                    logic [ems_pkg::CFG_W-1:0] d1,
                                    logic [ems_pkg::CFG_W-1:0] d2);
        logic [ems_pkg::CFG_W-1:0] vals [3];
        vals[0] = d0;
        vals[1] = d1;
        vals[2] = d2;
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= ems_pkg::CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            sb.write_delays(ems_pkg::CFG_IDX_W'(i), vals[i]);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            stall = draw_wait(out_burst);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_status(out_status);
        end
    end

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset delays are zero, so every move lands at once
        send_item(mk_item(ems_pkg::OP_TICK, mode_code(ems_pkg::M_SAFE)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_SAFE)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_MONO)));
        send_item(mk_item(ems_pkg::OP_CMD, REQ_FIRST_BAD));
        send_item(mk_item(ems_pkg::OP_CMD, REQ_MOST_NEG));
        send_item(mk_item(ems_pkg::OP_CMD, ems_pkg::REQ_ARM_ALIAS));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_BI)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_ARM)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_MONO)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_BI)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_MONO)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_ARM)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_SAFE)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_DUMP)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_ARM)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_SAFE)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_FILL)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_SAFE)));
        send_item(mk_item(ems_pkg::OP_FORCE, mode_code(ems_pkg::M_MONO)));
        send_item(mk_item(ems_pkg::OP_FORCE, REQ_HIGH_BAD));
        send_item(mk_item(OP_UNUSED, REQ_NEG_BAD));
        send_item(mk_item(ems_pkg::OP_FORCE, mode_code(ems_pkg::M_MONO)));
        send_item(mk_item(ems_pkg::OP_CMD, mode_code(ems_pkg::M_SAFE)));
        send_item(mk_item(ems_pkg::OP_TICK, ems_pkg::REQ_ARM_ALIAS));

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: write_delay_regs('1, '1, '1);
                1: write_delay_regs('0, '0, '0);
                2: write_delay_regs({$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom});
                default: write_delay_regs(short_delays(), short_delays(), short_delays());
            endcase
            in_burst  = (p % 3 == 1);
            out_burst = (p % 4 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item());
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
